### rtl/sensor_pair_normalize_detect_defines.svh
// Assertion macros for the sensor pair normalizer checker.
// Included by the checker file; expects clk and arst_n in scope.
`ifndef SENSOR_PAIR_NORMALIZE_DETECT_DEFINES_SVH
`define SENSOR_PAIR_NORMALIZE_DETECT_DEFINES_SVH

// same-cycle implication, disabled during reset
`define SPND_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled during reset
`define SPND_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/spnd_pkg.sv
// Shared types and constants for the sensor pair normalizer.
// No dependencies; imported by the lane, the top level and the checker.
`default_nettype none

package spnd_pkg;

	localparam int SUM_W    = 15;
	localparam int LEVEL_W  = 22;
	localparam int Q_W      = 16;
	localparam int SENS_W   = 4;
	localparam int SENSORS  = 16;
	localparam int MAP_W    = 16;
	localparam int PIDX_W   = 3;

	localparam logic [LEVEL_W-1:0] LEVEL_FULL = 22'd4161536;
	localparam logic [LEVEL_W-1:0] THR_RESET  = 22'd2097152;

	localparam logic CMD_SAMPLE = 1'b0;
	localparam logic CMD_CAL    = 1'b1;

	typedef struct packed {
		logic               done;
		logic               fault;
		logic [LEVEL_W-1:0] level;
	} spnd_lane_res_t;

endpackage

`default_nettype wire

### rtl/spnd_lane.sv
// One normalization lane: saturation checks, 16-step restoring divider, x127 scale.
// Depends on spnd_pkg.
`default_nettype none

module spnd_lane (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic                       ack,
	input  logic [spnd_pkg::SUM_W-1:0] v,
	input  logic [spnd_pkg::SUM_W-1:0] hi,
	input  logic [spnd_pkg::SUM_W-1:0] lo,
	output spnd_pkg::spnd_lane_res_t   res
);
	import spnd_pkg::*;

	localparam int CNT_W = $clog2(Q_W);

	typedef enum logic [3:0] {
		L_IDLE  = 4'b0001,
		L_DIV   = 4'b0010,
		L_SCALE = 4'b0100,
		L_HOLD  = 4'b1000
	} lane_state_t;

	lane_state_t        state_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [SUM_W:0]     rem_q;
	logic [SUM_W-1:0]   div_q;
	logic [Q_W-1:0]     quo_q;
	logic [LEVEL_W-1:0] level_q;
	logic               fault_q;

	logic               ge;
	logic [SUM_W:0]     diff;

	assign ge   = rem_q >= {1'b0, div_q};
	assign diff = ge ? (rem_q - {1'b0, div_q}) : rem_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= L_IDLE;
			cnt_q   <= '0;
		end else begin
			case (state_q)
				L_IDLE: begin
					if (start) begin
						if (v > hi || v < lo || hi == lo) begin
							state_q <= L_HOLD;
						end else begin
							state_q <= L_DIV;
							cnt_q   <= CNT_W'(Q_W - 1);
						end
					end
				end
				L_DIV: begin
					cnt_q <= cnt_q - 1'b1;
					if (cnt_q == '0) begin
						state_q <= L_SCALE;
					end
				end
				L_SCALE: begin
					state_q <= L_HOLD;
				end
				L_HOLD: begin
					if (ack) begin
						state_q <= L_IDLE;
					end
				end
				default: begin
					state_q <= L_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			L_IDLE: begin
				if (start) begin
					if (v > hi) begin
						level_q <= LEVEL_FULL;
						fault_q <= 1'b0;
					end else begin
						level_q <= '0;
						fault_q <= (v >= lo) && (hi == lo);
					end
					rem_q <= {1'b0, v - lo};
					div_q <= hi - lo;
					quo_q <= '0;
				end
			end
			L_DIV: begin
				quo_q <= {quo_q[Q_W-2:0], ge};
				rem_q <= {diff[SUM_W-1:0], 1'b0};
			end
			L_SCALE: begin
				level_q <= LEVEL_W'({quo_q, 7'b0}) - LEVEL_W'(quo_q);
			end
			default: begin
			end
		endcase
	end

	assign res.done  = (state_q == L_HOLD);
	assign res.fault = fault_q;
	assign res.level = level_q;

endmodule

`default_nettype wire

### rtl/sensor_pair_normalize_detect.sv
// Top level of the sensor pair normalizer: calibration store, two lanes, map merge.
// Depends on spnd_pkg and spnd_lane.
//
// Usage:
//   Input channel (in_valid/in_ready): one transaction per command. A calibration
//   write (command = 1) stores cal_max/cal_min for sensor_index on acceptance and
//   gives no result. A sample (command = 0) normalizes left_sum and right_sum of
//   the current pair in two lanes and gives one result on the output channel.
//   Output channel (out_valid/out_ready): pair index, both levels, the updated
//   detection map, scan_done on the last pair of a scan, and range_fault.
//   Config: cfg_we writes cfg_wdata into the detection threshold, no wait.
//   Flow: acceptance registers the sums and calibration, the lanes start, and
//   a lane runs its 16-step divider, one quotient bit per cycle, then scales;
//   a lane whose sum saturates or meets a zero range skips both. The result
//   is registered once both lanes are done; only then is a new transaction taken.
//   A stalled receiver holds the result register; the block finishes the next
//   sample and waits with it until the register frees up.
//   Reset clears the pair counter, the map, the output valid and all calibration
//   valid flags (entries read as zero until written), and loads the default threshold.
`default_nettype none

module sensor_pair_normalize_detect #(
	parameter int SENSOR_PAIRS = 8
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic                         command,
	input  logic [spnd_pkg::SENS_W-1:0]  sensor_index,
	input  logic [spnd_pkg::SUM_W-1:0]   left_sum,
	input  logic [spnd_pkg::SUM_W-1:0]   right_sum,
	input  logic [spnd_pkg::SUM_W-1:0]   cal_max,
	input  logic [spnd_pkg::SUM_W-1:0]   cal_min,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [spnd_pkg::PIDX_W-1:0]  pair_index,
	output logic [spnd_pkg::LEVEL_W-1:0] left_level,
	output logic [spnd_pkg::LEVEL_W-1:0] right_level,
	output logic [spnd_pkg::MAP_W-1:0]   detect_map,
	output logic                         scan_done,
	output logic                         range_fault,
	input  logic                         cfg_we,
	input  logic [spnd_pkg::LEVEL_W-1:0] cfg_wdata
);
	import spnd_pkg::*;

	localparam int PW = $clog2(SENSOR_PAIRS);

	typedef enum logic [2:0] {
		S_IDLE  = 3'b001,
		S_START = 3'b010,
		S_CALC  = 3'b100
	} top_state_t;

	top_state_t         state_q;
	logic [PW-1:0]      pair_q;
	logic [MAP_W-1:0]   map_q;
	logic [LEVEL_W-1:0] thr_q;
	logic [SENSORS-1:0] cal_valid_q;

	logic [SUM_W-1:0]   max_mem [SENSORS];
	logic [SUM_W-1:0]   min_mem [SENSORS];

	logic [SUM_W-1:0]   v_l_s1, v_r_s1;
	logic [SUM_W-1:0]   hi_l_s1, hi_r_s1, lo_l_s1, lo_r_s1;

	logic [SENS_W-1:0]  left_s, right_s;
	logic [PW:0]        right_raw;
	logic               acc, acc_sample, acc_cal;
	logic               lane_start, load;
	logic               last_pair;
	logic [MAP_W-1:0]   map_next;

	spnd_lane_res_t     res_l, res_r;

	logic               out_valid_q;
	logic [PIDX_W-1:0]  pair_index_q;
	logic [LEVEL_W-1:0] left_level_q, right_level_q;
	logic [MAP_W-1:0]   detect_map_q;
	logic               scan_done_q, range_fault_q;

	assign in_ready   = (state_q == S_IDLE);
	assign acc        = in_valid && in_ready;
	assign acc_sample = acc && (command == CMD_SAMPLE);
	assign acc_cal    = acc && (command == CMD_CAL);

	assign left_s     = SENS_W'(pair_q);
	assign right_raw  = {1'b0, pair_q} + (PW+1)'(SENSOR_PAIRS);
	assign right_s    = SENS_W'(right_raw);
	assign last_pair  = (pair_q == PW'(SENSOR_PAIRS - 1));

	assign lane_start = (state_q == S_START);
	assign load       = (state_q == S_CALC) && res_l.done && res_r.done
	                    && (!out_valid_q || out_ready);

	always_ff @(posedge clk) begin
		if (acc_cal) begin
			max_mem[sensor_index] <= cal_max;
			min_mem[sensor_index] <= cal_min;
		end
		if (acc_sample) begin
			v_l_s1  <= left_sum;
			v_r_s1  <= right_sum;
			hi_l_s1 <= cal_valid_q[left_s]  ? max_mem[left_s]  : '0;
			lo_l_s1 <= cal_valid_q[left_s]  ? min_mem[left_s]  : '0;
			hi_r_s1 <= cal_valid_q[right_s] ? max_mem[right_s] : '0;
			lo_r_s1 <= cal_valid_q[right_s] ? min_mem[right_s] : '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			pair_q      <= '0;
			map_q       <= '0;
			thr_q       <= THR_RESET;
			cal_valid_q <= '0;
		end else begin
			if (cfg_we) begin
				thr_q <= cfg_wdata;
			end
			if (acc_cal) begin
				cal_valid_q[sensor_index] <= 1'b1;
			end
			case (state_q)
				S_IDLE: begin
					if (acc_sample) begin
						state_q <= S_START;
					end
				end
				S_START: begin
					state_q <= S_CALC;
				end
				S_CALC: begin
					if (load) begin
						state_q <= S_IDLE;
						map_q   <= map_next;
						pair_q  <= last_pair ? '0 : pair_q + 1'b1;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	spnd_lane u_lane_left (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (lane_start),
		.ack    (load),
		.v      (v_l_s1),
		.hi     (hi_l_s1),
		.lo     (lo_l_s1),
		.res    (res_l)
	);

	spnd_lane u_lane_right (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (lane_start),
		.ack    (load),
		.v      (v_r_s1),
		.hi     (hi_r_s1),
		.lo     (lo_r_s1),
		.res    (res_r)
	);

	// right sensor applied last so it wins when both map to one bit
	always_comb begin
		map_next            = map_q;
		map_next[~left_s]   = res_l.level > thr_q;
		map_next[~right_s]  = res_r.level > thr_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			pair_index_q  <= PIDX_W'(pair_q);
			left_level_q  <= res_l.level;
			right_level_q <= res_r.level;
			detect_map_q  <= map_next;
			scan_done_q   <= last_pair;
			range_fault_q <= res_l.fault || res_r.fault;
		end
	end

	assign out_valid   = out_valid_q;
	assign pair_index  = pair_index_q;
	assign left_level  = left_level_q;
	assign right_level = right_level_q;
	assign detect_map  = detect_map_q;
	assign scan_done   = scan_done_q;
	assign range_fault = range_fault_q;

endmodule

`default_nettype wire

### rtl/spnd_checker.sv
// Port-level checks for the sensor pair normalizer, bound to the top level.
// Depends on spnd_pkg and sensor_pair_normalize_detect_defines.svh.
`default_nettype none
`include "sensor_pair_normalize_detect_defines.svh"

module spnd_checker #(
	parameter int SENSOR_PAIRS = 8
) (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         in_valid,
	input logic                         in_ready,
	input logic                         command,
	input logic                         out_valid,
	input logic                         out_ready,
	input logic [spnd_pkg::PIDX_W-1:0]  pair_index,
	input logic [spnd_pkg::LEVEL_W-1:0] left_level,
	input logic [spnd_pkg::LEVEL_W-1:0] right_level,
	input logic [spnd_pkg::MAP_W-1:0]   detect_map,
	input logic                         scan_done,
	input logic                         range_fault
);
	import spnd_pkg::*;

	`SPND_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(detect_map), "result dropped or changed while stalled")
	`SPND_ASSERT_NEXT(a_busy_after_sample, in_valid && in_ready && command == CMD_SAMPLE, !in_ready, "new transaction taken while a sample is in work")
	`SPND_ASSERT_NOW(a_level_range, out_valid, left_level <= LEVEL_FULL && right_level <= LEVEL_FULL, "level above full scale")
	`SPND_ASSERT_NOW(a_fault_zero, out_valid && range_fault, left_level == '0 || right_level == '0, "range fault without a zero level")
	`SPND_ASSERT_NOW(a_scan_last, out_valid && scan_done, pair_index == PIDX_W'(SENSOR_PAIRS - 1), "scan end on a pair other than the last")

endmodule

bind sensor_pair_normalize_detect spnd_checker #(
	.SENSOR_PAIRS (SENSOR_PAIRS)
) u_spnd_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (in_valid),
	.in_ready    (in_ready),
	.command     (command),
	.out_valid   (out_valid),
	.out_ready   (out_ready),
	.pair_index  (pair_index),
	.left_level  (left_level),
	.right_level (right_level),
	.detect_map  (detect_map),
	.scan_done   (scan_done),
	.range_fault (range_fault)
);

`default_nettype wire
